### src/fsw_pkg.sv
// ----------------------------------------------------------------------------
// fsw_pkg
// Shared types and constants for the FAT cluster-chain seek block.
// ----------------------------------------------------------------------------
package fsw_pkg;

	localparam int TABLE_BYTES = 8192;
	localparam int TAB_AW      = $clog2(TABLE_BYTES);
	// walk addresses reach 3*65535/2+1 and 2*65535+1, both below 2^17
	localparam int WALK_AW     = 17;
	localparam int CFG_IW      = 3;

	typedef enum logic [CFG_IW-1:0] {
		REG_BPS   = 3'd0,
		REG_SPC   = 3'd1,
		REG_START = 3'd2,
		REG_LEN   = 3'd3,
		REG_KIND  = 3'd4
	} cfg_reg_t;

	localparam logic [1:0] KIND_FAT12 = 2'd0;
	localparam logic [1:0] KIND_FAT16 = 2'd1;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_SEEK  = 1'b1;

	localparam logic [7:0] NIB_LO = 8'h0F;
	localparam logic [7:0] NIB_HI = 8'hF0;

	typedef struct packed {
		logic        action;
		logic [12:0] table_address;
		logic [7:0]  table_byte;
		logic [31:0] seek_offset;
	} in_t;

	typedef struct packed {
		logic [31:0] returned_offset;
		logic        clamped;
		logic [15:0] current_cluster;
		logic [6:0]  sector_idx;
		logic [11:0] byte_in_sector;
	} out_t;

	typedef struct packed {
		logic [12:0] bps;
		logic [7:0]  spc;
		logic [15:0] start;
		logic [31:0] len;
		logic [1:0]  kind;
	} cfg_t;

	typedef struct packed {
		logic ram_we;
		logic div_busy;
		logic walking;
	} stat_t;

endpackage

### src/fat_seek_cluster_walker.sv
// ----------------------------------------------------------------------------
// fat_seek_cluster_walker
// FAT12/FAT16 cluster chain seek over a byte table loaded by write items.
// ----------------------------------------------------------------------------
// A table write item finishes as it is taken. A seek item runs two 32-step
// divisions on one shared divider, then walks the chain, reading the low and
// then the high byte of each hop through the single port of the table RAM; a
// clamped seek skips both. Items wait in a two-entry input queue and one
// finished result waits in an output register while the next item runs.
module fat_seek_cluster_walker import fsw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  in_t               request,
	output logic              full,
	output logic              empty,
	input  logic              pop,
	output out_t              result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [31:0]       cfg_data
);

	cfg_t  cfg_q;
	logic  q_valid;
	in_t   q_item;
	logic  take;
	logic  res_valid;
	stat_t stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bps   <= 13'd512;
			cfg_q.spc   <= 8'd1;
			cfg_q.start <= '0;
			cfg_q.len   <= '0;
			cfg_q.kind  <= KIND_FAT12;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_BPS:   cfg_q.bps   <= cfg_data[12:0];
				REG_SPC:   cfg_q.spc   <= cfg_data[7:0];
				REG_START: cfg_q.start <= cfg_data[15:0];
				REG_LEN:   cfg_q.len   <= cfg_data;
				REG_KIND:  cfg_q.kind  <= cfg_data[1:0];
				default:   ;
			endcase
		end
	end

	fsw_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.request (request),
		.full    (full),
		.q_valid (q_valid),
		.q_item  (q_item),
		.take    (take)
	);

	fsw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.take      (take),
		.result    (result),
		.res_valid (res_valid),
		.pop       (pop),
		.stat      (stat)
	);

	assign empty = !res_valid;

	// the table port is never written while the chain walk or divider owns it
	a_we_excl: assert property (@(posedge clk) disable iff (!arst_n)
		stat.ram_we |-> !stat.walking && !stat.div_busy)
		else $error("table write during seek");

	a_div_walk: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_busy |-> !stat.walking)
		else $error("divider busy during walk");

	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> q_valid)
		else $error("item taken from empty queue");

endmodule

### src/fsw_ram.sv
// ----------------------------------------------------------------------------
// fsw_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module fsw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

### src/fsw_div.sv
// ----------------------------------------------------------------------------
// fsw_div
// Restoring divider, 32-bit dividend by 13-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module fsw_div import fsw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [12:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [31:0] quotient,
	output logic [12:0] remainder
);

	logic [31:0] quo_q;
	logic [12:0] rem_q;
	logic [12:0] dvs_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [13:0] trial;
	logic        fits;
	logic [13:0] diff;

	assign trial = {rem_q, quo_q[31]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[30:0], fits};
			rem_q <= fits ? diff[12:0] : trial[12:0];
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

### src/fsw_front.sv
// ----------------------------------------------------------------------------
// fsw_front
// Input side: two-entry queue that takes items and hands them to the back.
// ----------------------------------------------------------------------------
module fsw_front import fsw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  in_t  request,
	output logic full,
	output logic q_valid,
	output in_t  q_item,
	input  logic take
);

	in_t        ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_take;

	assign full    = cnt_q == 2'd2;
	assign do_push = push && !full;
	assign q_valid = cnt_q != 2'd0;
	assign do_take = take && q_valid;
	assign q_item  = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_take) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_take};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= request;
		end
	end

endmodule

### src/fsw_back.sv
// ----------------------------------------------------------------------------
// fsw_back
// Execution side: table writes, offset split and cluster chain walk.
// ----------------------------------------------------------------------------
module fsw_back import fsw_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  q_valid,
	input  in_t   q_item,
	output logic  take,
	output out_t  result,
	output logic  res_valid,
	input  logic  pop,
	output stat_t stat
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_DIV_SEC, ST_DIV_CLU, ST_WALK, ST_RD_HI, ST_NEXT, ST_FINISH
	} state_t;

	state_t      state_q;
	logic        res_valid_q;
	out_t        res_q;
	logic [15:0] pos_cluster_q;
	logic [6:0]  pos_sector_q;
	logic [11:0] pos_byte_q;
	logic [31:0] off_q;
	logic        clamp_q;
	logic [31:0] hops_q;
	logic [15:0] cur_q;
	logic [6:0]  sec_q;
	logic [11:0] byte_q;
	logic [7:0]  b0_q;
	logic        hi_oob_q;
	logic        lo_oob_q;
	logic        div_start_q;
	logic [31:0] div_a_q;
	logic [12:0] div_b_q;

	logic        div_busy;
	logic        div_done;
	logic [31:0] div_quo;
	logic [12:0] div_rem;
	logic [31:0] limit;
	logic [12:0] bps_eff;
	logic [7:0]  spc_eff;
	logic [WALK_AW-1:0] a_lo;
	logic [WALK_AW-1:0] a_hi;
	logic [WALK_AW-1:0] cur_ext;
	logic [TAB_AW-1:0]  ram_addr;
	logic        ram_we;
	logic [7:0]  ram_rdata;
	logic [7:0]  b1;
	logic [15:0] nxt;
	logic        is_fat12;
	logic        slot_free;

	assign limit    = cfg.len - 32'd1;
	assign bps_eff  = (cfg.bps == '0) ? 13'd1 : cfg.bps;
	assign spc_eff  = (cfg.spc == '0) ? 8'd1 : cfg.spc;
	assign is_fat12 = cfg.kind == KIND_FAT12;
	assign cur_ext  = {{(WALK_AW-16){1'b0}}, cur_q};
	// 3n/2 as n + n/2 keeps the sum inside the address width
	assign a_lo     = is_fat12 ? (cur_ext + (cur_ext >> 1)) : (cur_ext << 1);
	assign a_hi     = a_lo + 1'b1;
	assign take     = (state_q == ST_IDLE) && q_valid;
	assign ram_we   = take && (q_item.action == ACT_WRITE);
	assign slot_free = !res_valid_q || pop;

	always_comb begin
		case (state_q)
			ST_IDLE:  ram_addr = q_item.table_address;
			ST_WALK:  ram_addr = a_lo[TAB_AW-1:0];
			default:  ram_addr = a_hi[TAB_AW-1:0];
		endcase
	end

	// table bytes beyond the store read as zero
	assign b1 = hi_oob_q ? 8'd0 : ram_rdata;

	always_comb begin
		if (is_fat12) begin
			if (!cur_q[0]) begin
				nxt = {4'd0, b1[3:0] & NIB_LO[3:0], b0_q};
			end else begin
				nxt = {4'd0, b1, 4'd0} | {8'd0, 4'd0, b0_q[7:4] & NIB_HI[7:4]};
			end
		end else begin
			nxt = {b1, b0_q};
		end
	end

	fsw_ram #(.WIDTH(8), .DEPTH(TABLE_BYTES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (q_item.table_byte),
		.rdata (ram_rdata)
	);

	fsw_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start_q),
		.dividend  (div_a_q),
		.divisor   (div_b_q),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			res_valid_q   <= 1'b0;
			div_start_q   <= 1'b0;
			pos_cluster_q <= '0;
			pos_sector_q  <= '0;
			pos_byte_q    <= '0;
		end else begin
			div_start_q <= 1'b0;
			if (pop && res_valid_q && !(state_q == ST_FINISH && slot_free)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take && q_item.action == ACT_SEEK) begin
						if (q_item.seek_offset > limit) begin
							off_q   <= limit;
							clamp_q <= 1'b1;
							state_q <= ST_FINISH;
						end else begin
							off_q       <= q_item.seek_offset;
							clamp_q     <= 1'b0;
							div_a_q     <= q_item.seek_offset;
							div_b_q     <= bps_eff;
							div_start_q <= 1'b1;
							state_q     <= ST_DIV_SEC;
						end
					end
				end
				ST_DIV_SEC: begin
					if (div_done) begin
						byte_q      <= div_rem[11:0];
						div_a_q     <= div_quo;
						div_b_q     <= {5'd0, spc_eff};
						div_start_q <= 1'b1;
						state_q     <= ST_DIV_CLU;
					end
				end
				ST_DIV_CLU: begin
					if (div_done) begin
						hops_q  <= div_quo;
						sec_q   <= div_rem[6:0];
						cur_q   <= cfg.start;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (hops_q == '0) begin
						state_q <= ST_FINISH;
					end else if (cfg.kind != KIND_FAT12 && cfg.kind != KIND_FAT16) begin
						// chain collapses to cluster zero and stays there
						cur_q  <= '0;
						hops_q <= '0;
					end else begin
						lo_oob_q <= a_lo >= WALK_AW'(TABLE_BYTES);
						state_q  <= ST_RD_HI;
					end
				end
				ST_RD_HI: begin
					b0_q     <= lo_oob_q ? 8'd0 : ram_rdata;
					hi_oob_q <= a_hi >= WALK_AW'(TABLE_BYTES);
					state_q  <= ST_NEXT;
				end
				ST_NEXT: begin
					cur_q <= nxt;
					// a self-linked cluster ends the walk early
					hops_q  <= (nxt == cur_q) ? '0 : hops_q - 32'd1;
					state_q <= ST_WALK;
				end
				ST_FINISH: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						if (!clamp_q) begin
							pos_cluster_q <= cur_q;
							pos_sector_q  <= sec_q;
							pos_byte_q    <= byte_q;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && slot_free) begin
			res_q.returned_offset <= off_q;
			res_q.clamped         <= clamp_q;
			if (clamp_q) begin
				res_q.current_cluster <= pos_cluster_q;
				res_q.sector_idx      <= pos_sector_q;
				res_q.byte_in_sector  <= pos_byte_q;
			end else begin
				res_q.current_cluster <= cur_q;
				res_q.sector_idx      <= sec_q;
				res_q.byte_in_sector  <= byte_q;
			end
		end
	end

	assign result        = res_q;
	assign res_valid     = res_valid_q;
	assign stat.ram_we   = ram_we;
	assign stat.div_busy = div_busy;
	assign stat.walking  = (state_q == ST_WALK) || (state_q == ST_RD_HI) ||
		(state_q == ST_NEXT);

endmodule
